>>> rtl/mck_pkg.sv
// Shared constants, types and the Morse symbol table for the character keyer.
package mck_pkg;

    localparam int MCK_TABLE_ENTRIES = 37;
    localparam int MCK_ENTRY_W       = 16;
    localparam int MCK_UNIT_W        = 16;
    localparam int MCK_DUR_W         = 19;
    localparam logic [MCK_UNIT_W-1:0] MCK_UNIT_RESET = 16'd100;
    localparam logic [7:0] MCK_CHAR_SPACE = 8'h20;
    localparam logic [2:0] MCK_MAX_SYMBOLS = 3'd5;

    // Segment length in units of unit_time.
    typedef enum logic [1:0] {
        U_ONE,
        U_TWO,
        U_THREE,
        U_SEVEN
    } t_units;

    // Entry: valid, 7-bit char, 3-bit count, 5-bit pattern (bit 0 sent first, 1 = dash).
    function automatic logic [MCK_ENTRY_W-1:0] mck_ent(input logic [6:0] c,
                                                       input logic [2:0] n,
                                                       input logic [4:0] p);
        return {1'b1, c, n, p};
    endfunction

    function automatic logic [MCK_ENTRY_W-1:0] mck_entry(input int idx);
        logic [MCK_ENTRY_W-1:0] e;
        case (idx)
            0:       e = mck_ent(7'h41, 3'd2, 5'd2);
            1:       e = mck_ent(7'h42, 3'd4, 5'd1);
            2:       e = mck_ent(7'h43, 3'd4, 5'd5);
            3:       e = mck_ent(7'h44, 3'd3, 5'd1);
            4:       e = mck_ent(7'h45, 3'd1, 5'd0);
            5:       e = mck_ent(7'h46, 3'd4, 5'd4);
            6:       e = mck_ent(7'h47, 3'd3, 5'd3);
            7:       e = mck_ent(7'h48, 3'd4, 5'd0);
            8:       e = mck_ent(7'h49, 3'd2, 5'd0);
            9:       e = mck_ent(7'h4A, 3'd4, 5'd14);
            10:      e = mck_ent(7'h4B, 3'd3, 5'd5);
            11:      e = mck_ent(7'h4C, 3'd4, 5'd2);
            12:      e = mck_ent(7'h4D, 3'd2, 5'd3);
            13:      e = mck_ent(7'h4E, 3'd2, 5'd1);
            14:      e = mck_ent(7'h4F, 3'd3, 5'd7);
            15:      e = mck_ent(7'h50, 3'd4, 5'd6);
            16:      e = mck_ent(7'h51, 3'd4, 5'd11);
            17:      e = mck_ent(7'h52, 3'd3, 5'd2);
            18:      e = mck_ent(7'h53, 3'd3, 5'd0);
            19:      e = mck_ent(7'h54, 3'd1, 5'd1);
            20:      e = mck_ent(7'h55, 3'd3, 5'd4);
            21:      e = mck_ent(7'h56, 3'd4, 5'd8);
            22:      e = mck_ent(7'h57, 3'd3, 5'd6);
            23:      e = mck_ent(7'h58, 3'd4, 5'd9);
            24:      e = mck_ent(7'h59, 3'd4, 5'd13);
            25:      e = mck_ent(7'h5A, 3'd4, 5'd3);
            26:      e = mck_ent(7'h31, 3'd5, 5'd30);
            27:      e = mck_ent(7'h32, 3'd5, 5'd28);
            28:      e = mck_ent(7'h33, 3'd5, 5'd24);
            29:      e = mck_ent(7'h34, 3'd5, 5'd16);
            30:      e = mck_ent(7'h35, 3'd5, 5'd0);
            31:      e = mck_ent(7'h36, 3'd5, 5'd1);
            32:      e = mck_ent(7'h37, 3'd5, 5'd3);
            33:      e = mck_ent(7'h38, 3'd5, 5'd7);
            34:      e = mck_ent(7'h39, 3'd5, 5'd15);
            35:      e = mck_ent(7'h30, 3'd5, 5'd31);
            36:      e = mck_ent(7'h20, 3'd0, 5'd0);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

>>> rtl/mck_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mck_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 37
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/morse_character_keyer.sv
// Morse character keyer: looks up each ASCII character and emits lamp segments.
// After reset a table load pass writes every table entry; no input is taken meanwhile.
// Space: no table scan, the keyer goes straight to emitting. Letter/digit: the table is
// scanned one entry per cycle through the single RAM read port, until an entry matches or
// the last entry has been checked. Segments then leave at one per cycle while the receiver
// is ready; a new character is taken only once the previous one has been fully handled.
// Reset (synchronous, active low) clears the abort flag, sets unit_time to 100.
module morse_character_keyer
    import mck_pkg::*;
#(
    parameter int TABLE_ENTRIES = MCK_TABLE_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [MCK_UNIT_W-1:0] i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_character,
    input  logic                  i_message_start,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_led_on,
    output logic [MCK_DUR_W-1:0]  o_duration,
    output logic                  o_last
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] IDX_END  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] IDX_LAST = CW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        K_NONE,
        K_SPACE,
        K_LETTER
    } t_kind;

    t_state                r_state;
    t_kind                 r_kind;
    logic [CW-1:0]         r_idx;
    logic                  r_aborted;
    logic [MCK_UNIT_W-1:0] r_unit;
    logic [7:0]            r_char;
    logic                  r_pre;
    logic                  r_chk_vld;
    logic                  r_chk_last;
    logic [2:0]            r_n;
    logic [4:0]            r_pat;
    logic [2:0]            r_s;
    logic                  r_phase;
    logic                  r_ov;
    logic                  r_led;
    logic [MCK_DUR_W-1:0]  r_dur;
    logic                  r_last;

    logic                   ram_we;
    logic                   ram_re;
    logic [MCK_ENTRY_W-1:0] ram_rdata;
    logic                   hit;
    logic [2:0]             hit_n;

    logic   seg_led;
    t_units seg_units;
    logic   seg_last;
    logic   seg_done;
    logic   n_pre;
    logic   n_phase;
    logic [2:0] n_s;
    logic   load;

    assign ram_we = (r_state == S_FILL);
    assign ram_re = (r_state == S_SCAN) && (r_idx < IDX_END);

    mck_ram #(
        .WIDTH (MCK_ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (mck_entry(int'(r_idx))),
        .i_re    (ram_re),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // codes 128 and up never match
    assign hit   = ram_rdata[15] && (ram_rdata[14:8] == r_char[6:0]) && !r_char[7];
    assign hit_n = (ram_rdata[7:5] > MCK_MAX_SYMBOLS) ? MCK_MAX_SYMBOLS : ram_rdata[7:5];

    function automatic logic [MCK_DUR_W-1:0] seg_dur(input t_units u,
                                                     input logic [MCK_UNIT_W-1:0] t);
        logic [MCK_DUR_W-1:0] x;
        logic [MCK_DUR_W-1:0] d;
        x = MCK_DUR_W'(t);
        unique case (u)
            U_ONE:   d = x;
            U_TWO:   d = x << 1;
            U_THREE: d = (x << 1) + x;
            U_SEVEN: d = (x << 3) - x;
            default: d = x;
        endcase
        return d;
    endfunction

    // next segment of the current item
    always_comb begin
        seg_led   = 1'b0;
        seg_units = U_ONE;
        seg_last  = 1'b0;
        seg_done  = 1'b0;
        n_pre     = r_pre;
        n_phase   = r_phase;
        n_s       = r_s;
        if (r_pre) begin
            seg_units = U_TWO;
            seg_last  = (r_kind == K_NONE);
            seg_done  = (r_kind == K_NONE);
            n_pre     = 1'b0;
        end else if (r_kind == K_SPACE) begin
            seg_units = U_SEVEN;
            seg_last  = 1'b1;
            seg_done  = 1'b1;
        end else if (r_s < r_n) begin
            if (!r_phase) begin
                n_phase = 1'b1;
            end else begin
                seg_led   = 1'b1;
                seg_units = r_pat[r_s] ? U_THREE : U_ONE;
                n_phase   = 1'b0;
                n_s       = r_s + 3'd1;
            end
        end else begin
            seg_units = U_THREE;
            seg_last  = 1'b1;
            seg_done  = 1'b1;
        end
    end

    assign load = (r_state == S_EMIT) && (!r_ov || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_kind     <= K_NONE;
            r_idx      <= '0;
            r_aborted  <= 1'b0;
            r_unit     <= MCK_UNIT_RESET;
            r_pre      <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_chk_last <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_unit <= i_cfg_wr_data;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            r_chk_vld <= ram_re;

            unique case (r_state)
                S_FILL: begin
                    if (r_idx == IDX_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_char  <= i_character;
                        r_pre   <= i_message_start;
                        r_s     <= '0;
                        r_phase <= 1'b0;
                        r_idx   <= '0;
                        if (i_message_start || !r_aborted) begin
                            r_aborted <= 1'b0;
                            if (i_character == MCK_CHAR_SPACE) begin
                                r_kind  <= K_SPACE;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < IDX_END) begin
                        r_idx      <= r_idx + CW'(1);
                        r_chk_last <= (r_idx == IDX_LAST);
                    end
                    if (r_chk_vld) begin
                        if (hit) begin
                            r_n     <= hit_n;
                            r_pat   <= ram_rdata[4:0];
                            r_kind  <= K_LETTER;
                            r_state <= S_EMIT;
                        end else if (r_chk_last) begin
                            // unknown character: abandon the message
                            r_aborted <= 1'b1;
                            r_kind    <= K_NONE;
                            r_state   <= r_pre ? S_EMIT : S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_led   <= seg_led;
                        r_dur   <= seg_dur(seg_units, r_unit);
                        r_last  <= seg_last;
                        r_pre   <= n_pre;
                        r_phase <= n_phase;
                        r_s     <= n_s;
                        if (seg_done) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_led_on    = r_led;
    assign o_duration  = r_dur;
    assign o_last      = r_last;

endmodule

>>> tb/morse_character_keyer_test.sv
// Self-checking testbench for the Morse character keyer: random and directed characters.
`timescale 1ns / 100ps

module morse_character_keyer_test
    import mck_pkg::*;
();

    localparam int SETTLE_CYCLES = 100;   // covers the table load pass and a full table scan
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [7:0] ch;
        logic       start;
    } t_char_item;

    typedef struct {
        logic                 led;
        logic [MCK_DUR_W-1:0] dur;
        logic                 last;
    } t_segment;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_wr_en     = 1'b0;
    logic [MCK_UNIT_W-1:0] i_cfg_wr_data   = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_character     = '0;
    logic                  i_message_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic                  o_led_on;
    logic [MCK_DUR_W-1:0]  o_duration;
    logic                  o_last;

    t_char_item chars_to_send[$];
    t_segment   segments_due[$];

    logic [MCK_UNIT_W-1:0] unit_cfg = MCK_UNIT_RESET;
    logic                  msg_aborted = 1'b0;
    logic                  gen_aborted = 1'b0;
    int                    chars_offered = 0;
    int                    chars_accepted = 0;
    int                    error_count = 0;
    int                    idle_pct = 40;
    int                    stall_pct = 40;
    int                    gap_left = 0;
    int                    stall_left = 0;
    int                    hold_count = 0;
    logic                  hold_req = 1'b0;
    logic                  ready_next;
    t_char_item            next_char;
    t_segment              got_seg;
    string                 alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    morse_character_keyer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_character     (i_character),
        .i_message_start (i_message_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_led_on        (o_led_on),
        .o_duration      (o_duration),
        .o_last          (o_last)
    );

    always #2 i_clk = ~i_clk;

    // {symbol count, pattern}, first symbol in bit 0, 1 = dash
    function automatic logic morse_lookup(input logic [7:0] ch, output logic [7:0] code);
        logic found;
        found = 1'b1;
        case (ch)
            "A": code = {3'd2, 5'b00010};
            "B": code = {3'd4, 5'b00001};
            "C": code = {3'd4, 5'b00101};
            "D": code = {3'd3, 5'b00001};
            "E": code = {3'd1, 5'b00000};
            "F": code = {3'd4, 5'b00100};
            "G": code = {3'd3, 5'b00011};
            "H": code = {3'd4, 5'b00000};
            "I": code = {3'd2, 5'b00000};
            "J": code = {3'd4, 5'b01110};
            "K": code = {3'd3, 5'b00101};
            "L": code = {3'd4, 5'b00010};
            "M": code = {3'd2, 5'b00011};
            "N": code = {3'd2, 5'b00001};
            "O": code = {3'd3, 5'b00111};
            "P": code = {3'd4, 5'b00110};
            "Q": code = {3'd4, 5'b01011};
            "R": code = {3'd3, 5'b00010};
            "S": code = {3'd3, 5'b00000};
            "T": code = {3'd1, 5'b00001};
            "U": code = {3'd3, 5'b00100};
            "V": code = {3'd4, 5'b01000};
            "W": code = {3'd3, 5'b00110};
            "X": code = {3'd4, 5'b01001};
            "Y": code = {3'd4, 5'b01101};
            "Z": code = {3'd4, 5'b00011};
            "1": code = {3'd5, 5'b11110};
            "2": code = {3'd5, 5'b11100};
            "3": code = {3'd5, 5'b11000};
            "4": code = {3'd5, 5'b10000};
            "5": code = {3'd5, 5'b00000};
            "6": code = {3'd5, 5'b00001};
            "7": code = {3'd5, 5'b00011};
            "8": code = {3'd5, 5'b00111};
            "9": code = {3'd5, 5'b01111};
            "0": code = {3'd5, 5'b11111};
            default: begin
                code  = '0;
                found = 1'b0;
            end
        endcase
        return found;
    endfunction

    function automatic int unit_multiple(input t_units u);
        case (u)
            U_ONE:   return 1;
            U_TWO:   return 2;
            U_THREE: return 3;
            default: return 7;
        endcase
    endfunction

    function automatic void add_segment(input logic lit, input t_units u, input logic last);
        t_segment    seg;
        logic [31:0] prod;
        prod     = unit_cfg * unit_multiple(u);
        seg.led  = lit;
        seg.dur  = prod[MCK_DUR_W-1:0];
        seg.last = last;
        segments_due.push_back(seg);
    endfunction

    // Expected segments for one accepted character.
    function automatic void key_character(input logic [7:0] ch, input logic start);
        logic [7:0] code;
        t_segment   seg;
        if (start) begin
            msg_aborted = 1'b0;
            add_segment(1'b0, U_TWO, 1'b0);
        end
        if (!msg_aborted) begin
            if (ch == MCK_CHAR_SPACE) begin
                add_segment(1'b0, U_SEVEN, 1'b1);
            end else if (!morse_lookup(ch, code)) begin
                msg_aborted = 1'b1;
                if (start) begin
                    // the leading gap becomes the final segment
                    seg      = segments_due.pop_back();
                    seg.last = 1'b1;
                    segments_due.push_back(seg);
                end
            end else begin
                for (int s = 0; s < code[7:5]; s++) begin
                    add_segment(1'b0, U_ONE, 1'b0);
                    add_segment(1'b1, code[s] ? U_THREE : U_ONE, 1'b0);
                end
                add_segment(1'b0, U_THREE, 1'b1);
            end
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    task automatic add_char(input logic [7:0] ch, input logic start);
        t_char_item it;
        it.ch    = ch;
        it.start = start;
        chars_to_send.push_back(it);
    endtask

    // Mostly well-formed messages; a few unknown bytes abandon the message.
    task automatic add_random_chars(input int count);
        int         counted;
        int         r;
        logic [7:0] ch;
        logic [7:0] code;
        logic       st;
        counted = 0;
        while (counted < count) begin
            st = ($urandom_range(0, 99) < (gen_aborted ? 70 : 10));
            r  = $urandom_range(0, 99);
            if (r < 75)
                ch = alnum[$urandom_range(0, 35)];
            else if (r < 88)
                ch = MCK_CHAR_SPACE;
            else
                ch = 8'($urandom_range(0, 255));
            if (st)
                gen_aborted = 1'b0;
            if (!gen_aborted) begin
                counted++;
                if (ch != MCK_CHAR_SPACE && !morse_lookup(ch, code))
                    gen_aborted = 1'b1;
            end
            add_char(ch, st);
        end
    endtask

    task automatic write_unit(input logic [MCK_UNIT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        unit_cfg       = value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Wait until every character is taken and every segment has come out.
    task automatic drain();
        while (chars_to_send.size() != 0 || chars_accepted != chars_offered ||
               segments_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sender
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && chars_accepted != chars_offered)) begin
            if (i_in_valid && $urandom_range(0, 99) < idle_pct)
                gap_left = idle_len();
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (chars_to_send.size() != 0) begin
                next_char        = chars_to_send.pop_front();
                i_character     <= next_char.ch;
                i_message_start <= next_char.start;
                i_in_valid      <= 1'b1;
                chars_offered++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left = idle_len();
        end
        if (hold_count != 0)
            ready_next = 1'b0;
        i_out_ready <= ready_next;
    end

    always @(posedge i_clk) begin
        if (hold_req)
            hold_count <= HOLD_CYCLES;
        else if (hold_count != 0)
            hold_count <= hold_count - 1;
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                key_character(i_character, i_message_start);
                chars_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (segments_due.size() == 0) begin
                    flag_error($sformatf("unexpected segment led=%0b dur=%0d last=%0b",
                                         o_led_on, o_duration, o_last));
                end else begin
                    got_seg = segments_due.pop_front();
                    if (o_led_on !== got_seg.led || o_duration !== got_seg.dur ||
                        o_last !== got_seg.last)
                        flag_error($sformatf(
                            "expected led=%0b dur=%0d last=%0b, got led=%0b dur=%0d last=%0b",
                            got_seg.led, got_seg.dur, got_seg.last,
                            o_led_on, o_duration, o_last));
                end
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // directed: table extremes, spaces, abandoned messages, unknown codes
        write_unit(16'd3);
        add_char("A", 1'b1);
        add_char("Z", 1'b0);
        add_char(MCK_CHAR_SPACE, 1'b0);
        add_char("0", 1'b0);
        add_char("5", 1'b0);
        add_char("X", 1'b0);
        add_char("E", 1'b0);
        add_char("T", 1'b0);
        add_char("a", 1'b0);
        add_char("B", 1'b0);
        add_char(MCK_CHAR_SPACE, 1'b0);
        add_char("K", 1'b1);
        add_char(8'h00, 1'b1);
        add_char("M", 1'b0);
        add_char(8'hFF, 1'b1);
        add_char(MCK_CHAR_SPACE, 1'b1);
        add_char(8'hC1, 1'b0);
        add_char("Q", 1'b1);
        add_char(8'h80, 1'b0);
        add_char("9", 1'b1);
        add_char(8'h7F, 1'b0);
        add_char("5", 1'b1);
        add_char("Y", 1'b0);
        add_char("1", 1'b0);
        drain();

        // largest unit; receiver holds off while the sender keeps offering
        write_unit(16'hFFFF);
        idle_pct = 0;
        gen_aborted = 1'b1;
        add_random_chars(80);
        hold_req = 1'b1;
        @(negedge i_clk);
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        idle_pct = 40;
        drain();

        // smallest unit; no idling on either side for the first half
        write_unit(16'd1);
        idle_pct  = 0;
        stall_pct = 0;
        add_random_chars(40);
        drain();
        idle_pct  = 40;
        stall_pct = 40;
        add_random_chars(40);
        drain();

        // zero unit: every duration is zero
        write_unit(16'd0);
        add_random_chars(40);
        drain();

        write_unit(16'($urandom_range(1, 65535)));
        add_random_chars(40);
        drain();

        write_unit(16'($urandom_range(1, 255)));
        add_random_chars(40);
        drain();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
